[rtl/tsd_pkg.sv]
// Shared types, constants and helpers of the tar stream deframer.
// Used by tsd_front, tsd_back and tar_stream_deframer; no dependencies.
package tsd_pkg;

   localparam int BLOCK_BYTES       = 512;
   localparam int SIZE_FIELD_DIGITS = 12;
   localparam int IDX_W             = $clog2(BLOCK_BYTES);
   localparam int SIZE_W            = 36;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam logic [IDX_W-1:0] SIZE_FIRST = IDX_W'(124);
   localparam logic [IDX_W-1:0] SIZE_LAST  = IDX_W'(124 + SIZE_FIELD_DIGITS - 1);
   localparam logic [IDX_W-1:0] TYPE_INDEX = IDX_W'(156);
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(BLOCK_BYTES - 1);

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_FIVE  = 8'h35;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_D     = 8'h44;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_PAD,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_DATA,
      KIND_END,
      KIND_TRUNC
   } kind_type;

   typedef enum logic [1:0] {
      ENTRY_REGULAR,
      ENTRY_DIR,
      ENTRY_SYMLINK,
      ENTRY_OTHER
   } etype_type;

   typedef struct packed {
      kind_type            kind;
      etype_type           etype;
      logic [SIZE_W-1:0]   size;
      logic [7:0]          data;
      logic                last;
   } result_type;

   // One queue entry holds every result that a single input byte causes.
   typedef struct packed {
      logic       has_second;
      result_type first;
      result_type second;
   } entry_type;

   function automatic etype_type classify(input logic [7:0] c);
      etype_type t;
      if (c == CHAR_ZERO || c == CHAR_NUL) begin
         t = ENTRY_REGULAR;
      end else if (c == CHAR_FIVE || c == CHAR_D) begin
         t = ENTRY_DIR;
      end else if (c == CHAR_TWO) begin
         t = ENTRY_SYMLINK;
      end else begin
         t = ENTRY_OTHER;
      end
      return t;
   endfunction

endpackage

[rtl/tsd_front.sv]
// Front part of the tar stream deframer: walks the blocks byte by byte,
// parses headers and builds one queue entry per byte that yields results.
// Depends on tsd_pkg.
module tsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept_i,
   input  logic [7:0]          byte_i,
   input  logic                end_i,
   output logic                push_o,
   output tsd_pkg::entry_type  entry_o
);
   import tsd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SIZE_W-1:0]  acc_ff, acc_in;
   logic               field_end_ff, field_end_in;
   logic               all_zero_ff, all_zero_in;
   etype_type          type_ff, type_in;
   logic [SIZE_W-1:0]  remain_ff, remain_in;
   logic [SIZE_W-1:0]  remain_dec;
   logic               r0_valid;
   result_type         r0;
   logic               trunc;
   result_type         rt;

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      field_end_in = field_end_ff;
      all_zero_in  = all_zero_ff;
      type_in      = type_ff;
      remain_in    = remain_ff;
      remain_dec   = remain_ff - SIZE_W'(1);
      r0_valid     = 1'b0;
      r0           = '0;
      trunc        = 1'b0;
      rt           = '0;
      if (accept_i) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (byte_i != CHAR_NUL) all_zero_in = 1'b0;
               if (idx_ff >= SIZE_FIRST && idx_ff <= SIZE_LAST && !field_end_ff) begin
                  if (byte_i == CHAR_NUL) begin
                     field_end_in = 1'b1;
                  end else if (byte_i >= CHAR_ZERO && byte_i <= CHAR_SEVEN) begin
                     acc_in = {acc_ff[SIZE_W-4:0], byte_i[2:0]};
                  end
               end
               if (idx_ff == TYPE_INDEX) type_in = classify(byte_i);
               if (idx_ff == LAST_INDEX) begin
                  idx_in   = '0;
                  r0_valid = 1'b1;
                  if (all_zero_in) begin
                     r0.kind  = KIND_END;
                     phase_in = PH_DONE;
                  end else begin
                     r0.kind      = KIND_HEADER;
                     r0.etype     = type_in;
                     r0.size      = acc_in;
                     remain_in    = acc_in;
                     phase_in     = (acc_in != '0) ? PH_DATA : PH_HEADER;
                     acc_in       = '0;
                     field_end_in = 1'b0;
                     all_zero_in  = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_DATA: begin
               remain_in = remain_dec;
               if (type_ff == ENTRY_REGULAR) begin
                  r0_valid = 1'b1;
                  r0.kind  = KIND_DATA;
                  r0.size  = remain_dec;
                  r0.data  = byte_i;
                  r0.last  = (remain_dec == '0);
               end
               if (remain_dec == '0) begin
                  if (idx_ff == LAST_INDEX) begin
                     phase_in     = PH_HEADER;
                     idx_in       = '0;
                     acc_in       = '0;
                     field_end_in = 1'b0;
                     all_zero_in  = 1'b1;
                     type_in      = ENTRY_REGULAR;
                  end else begin
                     phase_in = PH_PAD;
                     idx_in   = idx_ff + IDX_W'(1);
                  end
               end else begin
                  // The index wraps to zero at the block boundary by its width.
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_PAD: begin
               if (idx_ff == LAST_INDEX) begin
                  phase_in     = PH_HEADER;
                  idx_in       = '0;
                  acc_in       = '0;
                  field_end_in = 1'b0;
                  all_zero_in  = 1'b1;
                  type_in      = ENTRY_REGULAR;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
         if (end_i) begin
            trunc    = (phase_in == PH_DATA) && (remain_in != '0);
            rt.kind  = KIND_TRUNC;
            rt.etype = type_in;
            rt.size  = remain_in;
            phase_in     = PH_HEADER;
            idx_in       = '0;
            acc_in       = '0;
            field_end_in = 1'b0;
            all_zero_in  = 1'b1;
            type_in      = ENTRY_REGULAR;
            remain_in    = '0;
         end
      end
      push_o = accept_i && (r0_valid || trunc);
      if (r0_valid) begin
         entry_o.first      = r0;
         entry_o.second     = rt;
         entry_o.has_second = trunc;
      end else begin
         entry_o.first      = rt;
         entry_o.second     = '0;
         entry_o.has_second = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         idx_ff       <= '0;
         acc_ff       <= '0;
         field_end_ff <= 1'b0;
         all_zero_ff  <= 1'b1;
         type_ff      <= ENTRY_REGULAR;
         remain_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         field_end_ff <= field_end_in;
         all_zero_ff  <= all_zero_in;
         type_ff      <= type_in;
         remain_ff    <= remain_in;
      end
   end

   // After the end of the archive nothing but a stream end moves the parser.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (idx_ff == '0 && !push_o))
      else $error("parser produced a result or moved its index after end of archive");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remain_ff != '0))
      else $error("data phase entered with no bytes remaining");

endmodule

[rtl/tsd_queue.sv]
// Small first-in first-out queue in flip-flops between the front and back
// parts of the deframer. No dependencies.
module tsd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  logic [WIDTH-1:0] push_data_i,
   input  logic             pop_i,
   output logic [WIDTH-1:0] pop_data_o,
   output logic             empty_o,
   output logic             full_o
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      empty_o    = (count_ff == '0);
      full_o     = (count_ff == CNT_FULL);
      do_push    = push_i && !full_o;
      do_pop     = pop_i && !empty_o;
      pop_data_o = store_ff[rd_ff];
      wr_in      = do_push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1)) : wr_ff;
      rd_in      = do_pop ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1)) : rd_ff;
      count_in   = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ff] <= push_data_i;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("queue push while full");

endmodule

[rtl/tsd_back.sv]
// Back part of the tar stream deframer: takes queue entries and delivers
// their one or two results through a registered output stage.
// Depends on tsd_pkg.
module tsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tsd_pkg::entry_type   head_i,
   input  logic                 empty_i,
   output logic                 pop_o,
   output logic                 valid_o,
   input  logic                 stall_i,
   output tsd_pkg::result_type  result_o
);
   import tsd_pkg::*;

   logic       sel_ff, sel_in;
   logic       valid_ff, valid_in;
   result_type result_ff, result_in;
   logic       load;

   always_comb begin
      load      = !valid_ff || !stall_i;
      sel_in    = sel_ff;
      valid_in  = valid_ff;
      result_in = result_ff;
      pop_o     = 1'b0;
      if (load) begin
         valid_in = !empty_i;
         if (!empty_i) begin
            result_in = sel_ff ? head_i.second : head_i.first;
            // An entry with a second result stays at the head for one more transfer.
            if (head_i.has_second && !sel_ff) begin
               sel_in = 1'b1;
            end else begin
               sel_in = 1'b0;
               pop_o  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign valid_o  = valid_ff;
   assign result_o = result_ff;

   a_second_pending: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (!empty_i && head_i.has_second && head_i.second.kind == KIND_TRUNC))
      else $error("second result pending without a matching queue entry");

endmodule

[rtl/tar_stream_deframer.sv]
// Top level of the tar stream deframer.
// Depends on tsd_pkg, tsd_front, tsd_queue and tsd_back.

// The deframer takes one byte of a decompressed tar stream per cycle and
// gives entry headers, file data bytes, an end-of-archive mark and a
// truncation mark as result transfers. A byte is taken in every cycle in
// which the result queue (QUEUE_DEPTH entries, one per byte that yields
// anything) has room; the parser itself never holds a byte back. A byte
// yields at most two results, the second always a truncation mark on the
// final byte, and the output register gives one result transfer per
// cycle while rsp_stall is low, so sustained throughput is one byte per cycle
// and only a stalled result side or a run of two-result bytes fills the queue.
// The first result of an accepted byte passes through the queue and then the output register.
module tar_stream_deframer #(
   parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_stream_byte,
   input  logic                      req_stream_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_item_kind,
   output logic [1:0]                rsp_entry_type,
   output logic [tsd_pkg::SIZE_W-1:0] rsp_entry_size,
   output logic [7:0]                rsp_data_out,
   output logic                      rsp_entry_last
);
   import tsd_pkg::*;

   logic       accept;
   logic       push;
   entry_type  push_entry;
   logic [$bits(entry_type)-1:0] head_bits;
   entry_type  head;
   logic       pop;
   logic       empty;
   logic       full;
   result_type result;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign head      = entry_type'(head_bits);

   tsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept_i (accept),
      .byte_i   (req_stream_byte),
      .end_i    (req_stream_end),
      .push_o   (push),
      .entry_o  (push_entry)
   );

   tsd_queue #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_entry),
      .pop_i       (pop),
      .pop_data_o  (head_bits),
      .empty_o     (empty),
      .full_o      (full)
   );

   tsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_i   (head),
      .empty_i  (empty),
      .pop_o    (pop),
      .valid_o  (rsp_valid),
      .stall_i  (rsp_stall),
      .result_o (result)
   );

   assign rsp_item_kind  = result.kind;
   assign rsp_entry_type = result.etype;
   assign rsp_entry_size = result.size;
   assign rsp_data_out   = result.data;
   assign rsp_entry_last = result.last;

endmodule

[bench/tsd_checker.sv]
// Result checker for the tar stream deframer: follows both channels, works out
// the results of every accepted byte and compares them with the result transfers.
// Depends on tsd_pkg.
module tsd_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [7:0]                 req_stream_byte,
   input  logic                       req_stream_end,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [1:0]                 rsp_item_kind,
   input  logic [1:0]                 rsp_entry_type,
   input  logic [tsd_pkg::SIZE_W-1:0] rsp_entry_size,
   input  logic [7:0]                 rsp_data_out,
   input  logic                       rsp_entry_last,
   output int                         mismatches,
   output int                         outstanding
);
   import tsd_pkg::*;

   phase_type         walk_phase;
   logic [IDX_W-1:0]  byte_index;
   logic [SIZE_W-1:0] size_digits;
   logic              size_closed;
   logic              block_blank;
   etype_type         entry_kind;
   logic [SIZE_W-1:0] bytes_left;
   result_type        predicted_items [$];

   task automatic open_header();
      walk_phase  = PH_HEADER;
      byte_index  = '0;
      size_digits = '0;
      size_closed = 1'b0;
      block_blank = 1'b1;
      entry_kind  = ENTRY_REGULAR;
   endtask

   task automatic predict(input kind_type k, input etype_type t, input logic [SIZE_W-1:0] s,
                          input logic [7:0] d, input logic l);
      result_type r;
      r.kind  = k;
      r.etype = t;
      r.size  = s;
      r.data  = d;
      r.last  = l;
      predicted_items.push_back(r);
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin);
      case (walk_phase)
         PH_HEADER: begin
            if (b != CHAR_NUL) block_blank = 1'b0;
            // Octal digits shift in until a NUL closes the field; anything else is skipped.
            if (byte_index >= SIZE_FIRST && byte_index <= SIZE_LAST && !size_closed) begin
               if (b == CHAR_NUL) size_closed = 1'b1;
               else if (b >= CHAR_ZERO && b <= CHAR_SEVEN) size_digits = {size_digits[SIZE_W-4:0], b[2:0]};
            end
            if (byte_index == TYPE_INDEX) begin
               case (b)
                  CHAR_ZERO, CHAR_NUL: entry_kind = ENTRY_REGULAR;
                  CHAR_FIVE, CHAR_D:   entry_kind = ENTRY_DIR;
                  CHAR_TWO:            entry_kind = ENTRY_SYMLINK;
                  default:             entry_kind = ENTRY_OTHER;
               endcase
            end
            if (byte_index == LAST_INDEX) begin
               byte_index = '0;
               if (block_blank) begin
                  predict(KIND_END, ENTRY_REGULAR, '0, 8'h00, 1'b0);
                  walk_phase = PH_DONE;
               end else begin
                  predict(KIND_HEADER, entry_kind, size_digits, 8'h00, 1'b0);
                  bytes_left  = size_digits;
                  walk_phase  = (size_digits != '0) ? PH_DATA : PH_HEADER;
                  size_digits = '0;
                  size_closed = 1'b0;
                  block_blank = 1'b1;
               end
            end else begin
               byte_index = byte_index + 1'b1;
            end
         end
         PH_DATA: begin
            bytes_left = bytes_left - 1'b1;
            if (entry_kind == ENTRY_REGULAR)
               predict(KIND_DATA, ENTRY_REGULAR, bytes_left, b, bytes_left == '0);
            if (bytes_left == '0 && byte_index == LAST_INDEX) begin
               open_header();
            end else begin
               if (bytes_left == '0) walk_phase = PH_PAD;
               byte_index = byte_index + 1'b1;
            end
         end
         PH_PAD: begin
            if (byte_index == LAST_INDEX) open_header();
            else byte_index = byte_index + 1'b1;
         end
         default: begin
         end
      endcase
      if (fin) begin
         if (walk_phase == PH_DATA && bytes_left != '0)
            predict(KIND_TRUNC, entry_kind, bytes_left, 8'h00, 1'b0);
         open_header();
         bytes_left = '0;
      end
   endtask

   task automatic check_field(input string what, input logic [SIZE_W-1:0] want,
                              input logic [SIZE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         open_header();
         bytes_left = '0;
         predicted_items.delete();
      end else begin
         if (req_valid && !req_stall) parse_byte(req_stream_byte, req_stream_end);
         if (rsp_valid && !rsp_stall) begin
            if (predicted_items.size() == 0) begin
               $display("%0t: result transfer with nothing pending, expected none, got kind %0d size %0h",
                        $time, rsp_item_kind, rsp_entry_size);
               mismatches++;
            end else begin
               want = predicted_items.pop_front();
               check_field("item_kind", want.kind, rsp_item_kind);
               check_field("entry_type", want.etype, rsp_entry_type);
               check_field("entry_size", want.size, rsp_entry_size);
               check_field("data_out", want.data, rsp_data_out);
               check_field("entry_last", want.last, rsp_entry_last);
            end
         end
      end
      outstanding = predicted_items.size();
   end

endmodule

[bench/tar_stream_deframer_tb.sv]
// Top of the tar stream deframer bench: builds tar archives and broken streams,
// drives them a byte at a time and gives the verdict.
// Depends on tsd_pkg, tar_stream_deframer and tsd_checker.
module tar_stream_deframer_tb;
   import tsd_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam logic [7:0] FLAG_HARDLINK = 8'h31;
   localparam logic [7:0] FLAG_LONGNAME = 8'h4C;

   logic              clock;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [7:0]        req_stream_byte = 8'h00;
   logic              req_stream_end  = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [1:0]        rsp_item_kind;
   logic [1:0]        rsp_entry_type;
   logic [SIZE_W-1:0] rsp_entry_size;
   logic [7:0]        rsp_data_out;
   logic              rsp_entry_last;
   int                mismatches;
   int                outstanding;

   bit                quiet         = 1'b0;
   bit                sender_bursty = 1'b1;
   int                stall_left    = 0;
   int                calm_left     = 0;
   int                live_bytes    = 0;
   logic [7:0]        hdr [BLOCK_BYTES];

   tar_stream_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_entry_type  (rsp_entry_type),
      .rsp_entry_size  (rsp_entry_size),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_last  (rsp_entry_last)
   );

   tsd_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_entry_type  (rsp_entry_type),
      .rsp_entry_size  (rsp_entry_size),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_last  (rsp_entry_last),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("tar_stream_deframer test failed");
      $finish;
   end

   // Result side back-pressure: bursts of stall, with the odd long calm stretch.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         calm_left  <= 0;
      end else if (calm_left > 0) begin
         rsp_stall <= 1'b0;
         calm_left <= calm_left - 1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 255) == 0) begin
         rsp_stall <= 1'b0;
         calm_left <= $urandom_range(100, 1000);
      end else if ($urandom_range(0, 11) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Returns once the byte has been taken; valid stays high into the next transfer.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (!quiet && sender_bursty && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      req_stream_end  <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Style 0 writes eleven digits and a NUL, style 1 twelve digits with no NUL,
   // style 2 the fewest digits with stray characters mixed in and noise after the NUL.
   task automatic build_header(input logic [7:0] flag, input logic [SIZE_W-1:0] size,
                               input int style);
      int digits;
      int pos;
      int room;
      int i;
      logic [7:0] c;
      for (i = 0; i < BLOCK_BYTES; i++)
         hdr[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CHAR_NUL;
      hdr[0] = 8'($urandom_range(1, 255));
      digits = 1;
      while (digits < 12 && (size >> (3 * digits)) != 0) digits++;
      if ((style == 0 && digits > 11) || (style == 2 && digits > 10)) style = 1;
      case (style)
         0: begin
            for (i = 0; i < 11; i++)
               hdr[int'(SIZE_FIRST) + i] = CHAR_ZERO | 8'((size >> (3 * (10 - i))) & 7);
            hdr[int'(SIZE_LAST)] = CHAR_NUL;
         end
         1: begin
            for (i = 0; i < 12; i++)
               hdr[int'(SIZE_FIRST) + i] = CHAR_ZERO | 8'((size >> (3 * (11 - i))) & 7);
         end
         default: begin
            if (size == '0 && $urandom_range(0, 1) == 1) digits = 0;
            room = 11 - digits;
            pos  = 0;
            for (i = digits; i >= 0; i--) begin
               while (room > 0 && $urandom_range(0, 2) == 0) begin
                  do c = 8'($urandom_range(1, 255)); while (c >= CHAR_ZERO && c <= CHAR_SEVEN);
                  hdr[int'(SIZE_FIRST) + pos] = c;
                  pos++;
                  room--;
               end
               if (i > 0) hdr[int'(SIZE_FIRST) + pos] = CHAR_ZERO | 8'((size >> (3 * (i - 1))) & 7);
               else hdr[int'(SIZE_FIRST) + pos] = CHAR_NUL;
               pos++;
            end
            for (; pos < 12; pos++)
               hdr[int'(SIZE_FIRST) + pos] = ($urandom_range(0, 1) == 0) ?
                  (CHAR_ZERO | 8'($urandom_range(0, 7))) : 8'($urandom_range(0, 255));
         end
      endcase
      hdr[TYPE_INDEX] = flag;
   endtask

   // Header, data and padding of one entry; the stream ends at byte cut of the
   // entry when cut is not negative.
   task automatic send_entry(input logic [7:0] flag, input logic [SIZE_W-1:0] size,
                             input int style, input longint cut, output bit ended);
      longint span;
      longint n;
      build_header(flag, size, style);
      ended = 1'b0;
      for (n = 0; n < BLOCK_BYTES && !ended; n++) begin
         ended = (n == cut);
         send_byte(hdr[n], ended);
      end
      live_bytes += int'(n);
      span = (longint'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES * BLOCK_BYTES;
      for (n = 0; n < span && !ended; n++) begin
         ended = (BLOCK_BYTES + n == cut);
         send_byte(8'($urandom_range(0, 255)), ended);
         if (n < longint'(size)) live_bytes++;
      end
   endtask

   // A zero block, cut short at byte cut if that is not negative, else followed
   // by extra bytes of the given value with the stream end on the last byte.
   task automatic send_trailer(input int cut, input int extra, input logic [7:0] fill);
      int i;
      bit ended;
      ended = 1'b0;
      for (i = 0; i < BLOCK_BYTES && !ended; i++) begin
         ended = (i == cut) || (cut < 0 && extra == 0 && i == BLOCK_BYTES - 1);
         send_byte(CHAR_NUL, ended);
      end
      for (i = 1; i <= extra && !ended; i++) send_byte(fill, i == extra);
   endtask

   task automatic send_archive();
      int entries;
      int style;
      logic [7:0] flag;
      logic [SIZE_W-1:0] size;
      longint span;
      longint cut;
      bit ended;
      entries = $urandom_range(1, 3);
      ended = 1'b0;
      for (int e = 0; e < entries && !ended; e++) begin
         case ($urandom_range(0, 9))
            5: flag = CHAR_NUL;
            6: flag = CHAR_FIVE;
            7: flag = CHAR_D;
            8: flag = CHAR_TWO;
            9: begin
               do flag = 8'($urandom_range(1, 255));
               while (flag == CHAR_ZERO || flag == CHAR_FIVE || flag == CHAR_D || flag == CHAR_TWO);
            end
            default: flag = CHAR_ZERO;
         endcase
         case ($urandom_range(0, 9))
            0: size = '0;
            7: size = SIZE_W'($urandom_range(41, 1100));
            8: size = SIZE_W'(BLOCK_BYTES * $urandom_range(1, 2));
            9: size = SIZE_W'(BLOCK_BYTES - 1 + 2 * $urandom_range(0, 1));
            default: size = SIZE_W'($urandom_range(1, 40));
         endcase
         style = $urandom_range(0, 2);
         span = (longint'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES * BLOCK_BYTES;
         cut = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, BLOCK_BYTES - 1 + span)) : -1;
         send_entry(flag, size, style, cut, ended);
      end
      if (!ended)
         send_trailer(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, BLOCK_BYTES - 1)) : -1,
                      ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 600)),
                      ($urandom_range(0, 1) == 0) ? CHAR_NUL : 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 1200);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
      live_bytes += n;
   endtask

   initial begin
      bit ended;
      int settle;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every type flag, zero sizes and skipped data, then the end block and ignored bytes.
      send_entry(CHAR_ZERO, 5, 0, -1, ended);
      send_entry(CHAR_NUL, 0, 0, -1, ended);
      send_entry(CHAR_FIVE, 0, 2, -1, ended);
      send_entry(CHAR_D, 3, 2, -1, ended);
      send_entry(CHAR_TWO, 0, 1, -1, ended);
      send_entry(FLAG_LONGNAME, 20, 0, -1, ended);
      send_entry(FLAG_HARDLINK, 0, 2, -1, ended);
      send_trailer(-1, 300, CHAR_NUL);
      // Data that fills a block exactly, stops one short of it and runs one past it.
      send_entry(CHAR_ZERO, 512, 1, -1, ended);
      send_entry(CHAR_ZERO, 511, 0, -1, ended);
      send_entry(CHAR_ZERO, 513, 2, -1, ended);
      send_trailer(-1, 0, CHAR_NUL);
      // Largest size the field holds, cut after three data bytes.
      send_entry(CHAR_ZERO, {SIZE_W{1'b1}}, 1, 514, ended);
      // Stream ends inside a header, on the last header byte with and without data
      // to follow, on the last data byte, in the padding and in skipped data.
      send_entry(CHAR_ZERO, 7, 0, 100, ended);
      send_entry(CHAR_ZERO, 9, 0, 511, ended);
      send_entry(CHAR_ZERO, 0, 0, 511, ended);
      send_entry(CHAR_ZERO, 4, 0, 515, ended);
      send_entry(CHAR_ZERO, 4, 0, 600, ended);
      send_entry(CHAR_D, 100, 0, 550, ended);
      // An archive that opens with its end block, then one cut inside a zero block.
      send_trailer(-1, 40, 8'hFF);
      send_trailer(200, 0, CHAR_NUL);
      send_byte(8'h5A, 1'b1);
      send_byte(CHAR_NUL, 1'b1);

      live_bytes = 0;
      while (live_bytes < RANDOM_ITEMS) begin
         sender_bursty = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_archive();
      end
      quiet = 1'b1;
      send_entry(CHAR_ZERO, SIZE_W'($urandom_range(1, 40)), 0, -1, ended);
      send_trailer(-1, 0, CHAR_NUL);

      req_valid <= 1'b0;
      settle = 0;
      while (outstanding != 0 && settle < 20000) begin
         @(posedge clock);
         settle++;
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tar_stream_deframer test passed");
      end else begin
         $display("tar_stream_deframer test failed");
      end
      $finish;
   end

endmodule
